// ----- hdl/icdf_pkg.sv -----
package icdf_pkg;

	// default table size
	localparam int TABLE_DEPTH_DEF = 1024;

	// field widths
	localparam int IDX_W      = 10;
	localparam int VAL_W      = 33;
	localparam int LIM_W      = 32;
	localparam int BC_W       = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// divider geometry: product numerator and quotient bits
	localparam int NUM_W = 65;
	localparam int QUO_W = 42;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS  = 2'd2;

	// request kinds
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// register reset values
	localparam logic [LIM_W-1:0] LOWER_RST = 32'h0000_0000;
	localparam logic [LIM_W-1:0] UPPER_RST = 32'h0001_0000;
	localparam logic [BC_W-1:0]  BINS_RST  = 11'd1024;

	// constants of the arithmetic
	localparam logic [QUO_W-1:0] TERM_CAP = 42'h200_0000_0000;
	localparam logic [LIM_W-1:0] ONE_Q16  = 32'h0001_0000;
	localparam logic [LIM_W-1:0] SAT_MAX  = 32'h7FFF_FFFF;
	localparam logic [LIM_W-1:0] SAT_MIN  = 32'h8000_0000;

	// control carried through the search stages
	typedef struct packed {
		logic wr;
		logic smp;
		logic chk;
	} ctl_t;

	// control carried through the arithmetic stages
	typedef struct packed {
		logic             vld;
		logic             zero;
		logic             one;
		logic             flat;
		logic             neg;
		logic             eneg;
		logic             ovf;
		logic [IDX_W-1:0] bin;
	} meta_t;

endpackage

// ----- hdl/icdf_level.sv -----
module icdf_level import icdf_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             ctl,
	input  logic [VAL_W-1:0] val,
	input  logic [AW-1:0]    waddr,
	input  logic [AW-1:0]    first,
	input  logic [AW-1:0]    last,
	input  logic [AW-1:0]    mid,
	input  logic [VAL_W-1:0] rd,
	output ctl_t             ctl_s,
	output logic [VAL_W-1:0] val_s,
	output logic [AW-1:0]    waddr_s,
	output logic [AW-1:0]    first_s,
	output logic [AW-1:0]    last_s,
	output logic [AW-1:0]    mid_s,
	output logic [VAL_W-1:0] rd_s
);

	// table copy for this search step
	logic [VAL_W-1:0] mem [DEPTH];

	logic [AW-1:0] f_n;
	logic [AW-1:0] l_n;
	logic [AW-1:0] m_n;
	logic [AW:0]   sum;

	// settle the previous step, then pick the next probe
	always_comb begin
		f_n = first;
		l_n = last;
		if (ctl.chk && ctl.smp && (first < last)) begin
			if (val < rd) begin
				l_n = mid;
			end else if (val > rd) begin
				f_n = mid + AW'(1);
			end else begin
				f_n = mid;
				l_n = mid;
			end
		end
		sum = {1'b0, f_n} + {1'b0, l_n};
		m_n = sum[AW:1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else if (en) begin
			ctl_s <= '{wr: ctl.wr, smp: ctl.smp, chk: 1'b1};
		end
	end

	// payload, table write and probe read
	always_ff @(posedge clk) begin
		if (en) begin
			val_s   <= val;
			waddr_s <= waddr;
			first_s <= f_n;
			last_s  <= l_n;
			mid_s   <= m_n;
			rd_s    <= mem[m_n];
			if (ctl.wr) begin
				mem[waddr] <= val;
			end
		end
	end

endmodule

// ----- hdl/icdf_fetch.sv -----
module icdf_fetch import icdf_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             ctl,
	input  logic [VAL_W-1:0] val,
	input  logic [AW-1:0]    waddr,
	input  logic [AW-1:0]    first,
	input  logic [AW-1:0]    last,
	input  logic [AW-1:0]    mid,
	input  logic [VAL_W-1:0] rd,
	output ctl_t             ctl_s,
	output logic [VAL_W-1:0] u_s,
	output logic [AW-1:0]    bin_s,
	output logic [VAL_W-1:0] rb_s,
	output logic [VAL_W-1:0] rp_s,
	output logic             bz_s
);

	// table copy read at the bin and the bin below
	logic [VAL_W-1:0] mem [DEPTH];

	logic [AW-1:0] b;
	logic [AW-1:0] bm1;

	// last search step
	always_comb begin
		b = first;
		if (ctl.smp && (first < last)) begin
			if (val > rd) begin
				b = mid + AW'(1);
			end else begin
				b = mid;
			end
		end
		bm1 = b - AW'(1);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else if (en) begin
			ctl_s <= ctl;
		end
	end

	// payload, table write and bin reads
	always_ff @(posedge clk) begin
		if (en) begin
			u_s   <= val;
			bin_s <= b;
			bz_s  <= (b == '0);
			rb_s  <= mem[b];
			rp_s  <= mem[bm1];
			if (ctl.wr) begin
				mem[waddr] <= val;
			end
		end
	end

endmodule

// ----- hdl/icdf_div.sv -----
module icdf_div import icdf_pkg::*; #(
	parameter int NW = NUM_W,
	parameter int DW = 44,
	parameter int QW = QUO_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	// one quotient bit per stage
	logic [DW-1:0] rem_r [QW];
	logic [QW-1:0] lo_r  [QW];
	logic [QW-1:0] q_r   [QW];
	logic [DW-1:0] den_r [QW];

	logic [DW-1:0] rem_src [QW];
	logic [QW-1:0] lo_src  [QW];
	logic [QW-1:0] q_src   [QW];
	logic [DW-1:0] den_src [QW];

	logic [DW-1:0] rem_nx [QW];
	logic [QW-1:0] lo_nx  [QW];
	logic [QW-1:0] q_nx   [QW];

	logic [DW:0] trial [QW];

	// stage inputs
	always_comb begin
		rem_src[0] = DW'(num >> QW);
		lo_src[0]  = num[QW-1:0];
		q_src[0]   = '0;
		den_src[0] = den;
		for (int i = 1; i < QW; i++) begin
			rem_src[i] = rem_r[i-1];
			lo_src[i]  = lo_r[i-1];
			q_src[i]   = q_r[i-1];
			den_src[i] = den_r[i-1];
		end
	end

	// compare and subtract
	always_comb begin
		for (int i = 0; i < QW; i++) begin
			trial[i] = {rem_src[i], lo_src[i][QW-1]};
			lo_nx[i] = {lo_src[i][QW-2:0], 1'b0};
			if (trial[i] >= {1'b0, den_src[i]}) begin
				rem_nx[i] = DW'(trial[i] - {1'b0, den_src[i]});
				q_nx[i]   = {q_src[i][QW-2:0], 1'b1};
			end else begin
				rem_nx[i] = trial[i][DW-1:0];
				q_nx[i]   = {q_src[i][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QW; i++) begin
				rem_r[i] <= rem_nx[i];
				lo_r[i]  <= lo_nx[i];
				q_r[i]   <= q_nx[i];
				den_r[i] <= den_src[i];
			end
		end
	end

	assign quo = q_r[QW-1];

endmodule

// ----- hdl/icdf_arith.sv -----
module icdf_arith import icdf_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  ctl_t                    ctl,
	input  logic [VAL_W-1:0]        u,
	input  logic [AW-1:0]           bin,
	input  logic [VAL_W-1:0]        rb,
	input  logic [VAL_W-1:0]        rp,
	input  logic                    bz,
	input  logic signed [LIM_W-1:0] lower,
	input  logic signed [LIM_W-1:0] upper,
	input  logic [AW:0]             n,
	output logic                    rsp_valid,
	output logic signed [LIM_W-1:0] sample_value,
	output logic [IDX_W-1:0]        bin_found,
	output logic                    flat_bin,
	output logic                    saturated
);

	localparam int DW  = AW + 1 + VAL_W;
	localparam int EW  = 32 + AW + 1;
	localparam int XW  = QUO_W + 4;

	// stage 1: differences, magnitudes and signs
	logic [VAL_W-1:0]  prev;
	logic signed [33:0] a;
	logic signed [32:0] diff;
	logic [VAL_W-1:0]  d;
	logic [AW+IDX_W-1:0] bext;
	meta_t             m1;

	always_comb begin
		prev = bz ? '0 : rp;
		a    = $signed({1'b0, u}) - $signed({1'b0, rb});
		diff = $signed({upper[LIM_W-1], upper}) - $signed({lower[LIM_W-1], lower});
		d    = (rb >= prev) ? (rb - prev) : (prev - rb);
		bext = (AW+IDX_W)'(bin);
		m1.vld  = ctl.smp;
		m1.zero = (u == '0);
		m1.one  = u[VAL_W-1];
		m1.flat = (rb == prev);
		m1.neg  = a[33] ^ diff[32] ^ (rb < prev);
		m1.eneg = diff[32];
		m1.ovf  = 1'b0;
		m1.bin  = bext[IDX_W-1:0];
	end

	meta_t            meta_s1;
	logic [32:0]      ad_s1;
	logic [31:0]      dd_s1;
	logic [VAL_W-1:0] d_s1;
	logic [AW:0]      bp1_s1;

	logic [33:0] a_abs;
	logic [32:0] diff_abs;

	assign a_abs    = a[33] ? 34'(-a) : 34'(a);
	assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s1  <= a_abs[32:0];
			dd_s1  <= diff_abs[31:0];
			d_s1   <= d;
			bp1_s1 <= (AW+1)'(bin) + (AW+1)'(1);
		end
	end

	// stage 2: partial products
	meta_t        meta_s2;
	logic [48:0]  plo_s2;
	logic [48:0]  phi_s2;
	logic [DW-1:0] dent_s2;
	logic [EW-1:0] nume_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s2  <= 49'(ad_s1) * 49'(dd_s1[15:0]);
			phi_s2  <= 49'(ad_s1) * 49'(dd_s1[31:16]);
			dent_s2 <= DW'(n) * DW'(d_s1);
			nume_s2 <= EW'(dd_s1) * EW'(bp1_s1);
		end
	end

	// stage 3: full product
	meta_t          meta_s3;
	logic [NUM_W-1:0] numt_s3;
	logic [NUM_W-1:0] nume_s3;
	logic [DW-1:0]    dent_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			numt_s3 <= (NUM_W'(phi_s2) << 16) + NUM_W'(plo_s2);
			nume_s3 <= NUM_W'(nume_s2);
			dent_s3 <= dent_s2;
		end
	end

	// metadata registers of the first three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else if (en) begin
			meta_s1 <= m1;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
		end
	end

	// quotient too large for the divider: term is capped
	meta_t m3;
	always_comb begin
		m3     = meta_s3;
		m3.ovf = (numt_s3 >> QUO_W) >= NUM_W'(dent_s3);
	end

	// dividers: interpolation term and bin edge offset
	logic [QUO_W-1:0] q_t;
	logic [QUO_W-1:0] q_e;

	icdf_div #(
		.NW(NUM_W),
		.DW(DW),
		.QW(QUO_W)
	) u_div_term (
		.clk(clk),
		.en (en),
		.num(numt_s3),
		.den(dent_s3),
		.quo(q_t)
	);

	icdf_div #(
		.NW(NUM_W),
		.DW(DW),
		.QW(QUO_W)
	) u_div_edge (
		.clk(clk),
		.en (en),
		.num(nume_s3),
		.den(DW'(n)),
		.quo(q_e)
	);

	// metadata alongside the dividers
	meta_t mp [QUO_W];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUO_W; i++) begin
				mp[i] <= '0;
			end
		end else if (en) begin
			mp[0] <= m3;
			for (int i = 1; i < QUO_W; i++) begin
				mp[i] <= mp[i-1];
			end
		end
	end

	// stage 4: signed terms
	meta_t               meta_s4;
	logic signed [QUO_W:0] term_s4;
	logic signed [33:0]    eo_s4;
	logic [QUO_W-1:0]      mag;
	meta_t               mt;

	always_comb begin
		mt = mp[QUO_W-1];
		if (mt.ovf || (q_t > TERM_CAP)) begin
			mag = TERM_CAP;
		end else begin
			mag = q_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s4 <= '0;
		end else if (en) begin
			meta_s4 <= mt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (mt.flat) begin
				term_s4 <= '0;
			end else if (mt.neg) begin
				term_s4 <= -$signed({1'b0, mag});
			end else begin
				term_s4 <= $signed({1'b0, mag});
			end
			if (mt.eneg) begin
				eo_s4 <= -$signed({1'b0, q_e[32:0]});
			end else begin
				eo_s4 <= $signed({1'b0, q_e[32:0]});
			end
		end
	end

	// stage 5: sum, saturate and select special cases
	logic signed [XW-1:0] x;
	logic signed [LIM_W-1:0] val_n;
	logic                 sat_n;

	always_comb begin
		x = XW'(lower) + XW'(eo_s4) + XW'(term_s4);
		if (x > XW'($signed(SAT_MAX))) begin
			val_n = $signed(SAT_MAX);
			sat_n = 1'b1;
		end else if (x < XW'($signed(SAT_MIN))) begin
			val_n = $signed(SAT_MIN);
			sat_n = 1'b1;
		end else begin
			val_n = x[LIM_W-1:0];
			sat_n = 1'b0;
		end
	end

	logic                    valid_s5;
	logic signed [LIM_W-1:0] value_s5;
	logic [IDX_W-1:0]        bin_s5;
	logic                    flat_s5;
	logic                    sat_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= meta_s4.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (meta_s4.zero) begin
				value_s5 <= '0;
				bin_s5   <= '0;
				flat_s5  <= 1'b0;
				sat_s5   <= 1'b0;
			end else if (meta_s4.one) begin
				value_s5 <= $signed(ONE_Q16);
				bin_s5   <= '0;
				flat_s5  <= 1'b0;
				sat_s5   <= 1'b0;
			end else begin
				value_s5 <= val_n;
				bin_s5   <= meta_s4.bin;
				flat_s5  <= meta_s4.flat;
				sat_s5   <= sat_n;
			end
		end
	end

	assign rsp_valid    = valid_s5;
	assign sample_value = value_s5;
	assign bin_found    = bin_s5;
	assign flat_bin     = flat_s5;
	assign saturated    = sat_s5;

endmodule

// ----- hdl/inverse_cdf_sampler_top.sv -----
// Inverse-transform sampler over a piecewise-linear cumulative table.
// Configuration: cfg_we writes cfg_data into register cfg_index (lower limit,
// upper limit, bin count); write only while no request is in flight.
// Request channel (req_valid / req_stall): action selects a table load
// (entry_index, entry_value) or a sample draw (uniform_value). A load makes
// no response; a sample makes exactly one on the response channel
// (rsp_valid / rsp_stall) with sample_value, bin_found, flat_bin, saturated.
// Throughput: one request per cycle while no stalled response holds the
// pipeline. A sample passes the entry stage, the binary search steps, each
// reading its own copy of the table, then a two-port table fetch, three
// arithmetic stages (differences, partial products, full product),
// a 42-stage radix-2 divider and two output stages.
// A load updates each table copy as it passes, so later samples see it.
// Reset clears pipeline valid bits and the registers to lower 0, upper 1.0,
// 1024 bins; table contents are undefined until loaded.
// When rsp_stall is high with a response pending the whole pipeline holds
// and req_stall rises; nothing is lost or repeated.
module inverse_cdf_sampler_top import icdf_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    action,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic [VAL_W-1:0]        entry_value,
	input  logic [VAL_W-1:0]        uniform_value,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic signed [LIM_W-1:0] sample_value,
	output logic [IDX_W-1:0]        bin_found,
	output logic                    flat_bin,
	output logic                    saturated
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int LVLS = AW;

	// configuration registers
	logic signed [LIM_W-1:0] lower_q;
	logic signed [LIM_W-1:0] upper_q;
	logic [BC_W-1:0]         bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= $signed(LOWER_RST);
			upper_q <= $signed(UPPER_RST);
			bins_q  <= BINS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOWER: lower_q <= $signed(cfg_data);
				CFG_UPPER: upper_q <= $signed(cfg_data);
				CFG_BINS:  bins_q  <= cfg_data[BC_W-1:0];
				default: ;
			endcase
		end
	end

	// bins in use, clamped to one and to the table size
	logic [31:0] n_w;
	logic [AW:0] n;

	always_comb begin
		if (bins_q == '0) begin
			n_w = 32'd1;
		end else if (32'(bins_q) > 32'(TABLE_DEPTH)) begin
			n_w = 32'(TABLE_DEPTH);
		end else begin
			n_w = 32'(bins_q);
		end
		n = n_w[AW:0];
	end

	// global advance: hold everything while a response waits
	logic en;
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	// entry stage
	logic [AW+IDX_W-1:0] idx_ext;
	logic                idx_ok;
	logic [AW-1:0]       last0;

	assign idx_ext = (AW+IDX_W)'(entry_index);
	assign idx_ok  = (32'(entry_index) < 32'(TABLE_DEPTH));
	assign last0   = AW'(n - (AW+1)'(1));

	ctl_t             ctl_s1;
	logic [VAL_W-1:0] val_s1;
	logic [AW-1:0]    waddr_s1;
	logic [AW-1:0]    last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= '{wr: req_valid && (action == ACT_LOAD) && idx_ok,
				smp: req_valid && (action == ACT_SAMPLE), chk: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s1   <= (action == ACT_SAMPLE) ? uniform_value : entry_value;
			waddr_s1 <= idx_ext[AW-1:0];
			last_s1  <= last0;
		end
	end

	// search chain
	ctl_t             ctl_a   [LVLS+1];
	logic [VAL_W-1:0] val_a   [LVLS+1];
	logic [AW-1:0]    waddr_a [LVLS+1];
	logic [AW-1:0]    first_a [LVLS+1];
	logic [AW-1:0]    last_a  [LVLS+1];
	logic [AW-1:0]    mid_a   [LVLS+1];
	logic [VAL_W-1:0] rd_a    [LVLS+1];

	assign ctl_a[0]   = ctl_s1;
	assign val_a[0]   = val_s1;
	assign waddr_a[0] = waddr_s1;
	assign first_a[0] = '0;
	assign last_a[0]  = last_s1;
	assign mid_a[0]   = '0;
	assign rd_a[0]    = '0;

	for (genvar k = 0; k < LVLS; k++) begin : g_lvl
		icdf_level #(
			.DEPTH(TABLE_DEPTH)
		) u_level (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl    (ctl_a[k]),
			.val    (val_a[k]),
			.waddr  (waddr_a[k]),
			.first  (first_a[k]),
			.last   (last_a[k]),
			.mid    (mid_a[k]),
			.rd     (rd_a[k]),
			.ctl_s  (ctl_a[k+1]),
			.val_s  (val_a[k+1]),
			.waddr_s(waddr_a[k+1]),
			.first_s(first_a[k+1]),
			.last_s (last_a[k+1]),
			.mid_s  (mid_a[k+1]),
			.rd_s   (rd_a[k+1])
		);
	end

	// bin entries
	ctl_t             ctl_f;
	logic [VAL_W-1:0] u_f;
	logic [AW-1:0]    bin_f;
	logic [VAL_W-1:0] rb_f;
	logic [VAL_W-1:0] rp_f;
	logic             bz_f;

	icdf_fetch #(
		.DEPTH(TABLE_DEPTH)
	) u_fetch (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.ctl   (ctl_a[LVLS]),
		.val   (val_a[LVLS]),
		.waddr (waddr_a[LVLS]),
		.first (first_a[LVLS]),
		.last  (last_a[LVLS]),
		.mid   (mid_a[LVLS]),
		.rd    (rd_a[LVLS]),
		.ctl_s (ctl_f),
		.u_s   (u_f),
		.bin_s (bin_f),
		.rb_s  (rb_f),
		.rp_s  (rp_f),
		.bz_s  (bz_f)
	);

	// interpolation
	icdf_arith #(
		.DEPTH(TABLE_DEPTH)
	) u_arith (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctl         (ctl_f),
		.u           (u_f),
		.bin         (bin_f),
		.rb          (rb_f),
		.rp          (rp_f),
		.bz          (bz_f),
		.lower       (lower_q),
		.upper       (upper_q),
		.n           (n),
		.rsp_valid   (rsp_valid),
		.sample_value(sample_value),
		.bin_found   (bin_found),
		.flat_bin    (flat_bin),
		.saturated   (saturated)
	);

endmodule

// ----- hdl/icdf_checker.sv -----
module icdf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] sample_value,
	input logic        flat_bin,
	input logic        saturated
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(sample_value))
		else $error("stalled response changed");

	// a stalled response blocks new requests
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response stalled");

	// a bin edge always lies inside the range
	a_flat_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && flat_bin |-> !saturated)
		else $error("flat bin result saturated");

	// clipped values sit at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && saturated |->
			(sample_value == 32'h7FFF_FFFF) || (sample_value == 32'h8000_0000))
		else $error("saturated value off the rail");

endmodule

bind inverse_cdf_sampler_top icdf_checker u_icdf_checker (.*);

// ----- verif/tb.sv -----
module tb import icdf_pkg::*;;

	// one request as offered on the request channel
	typedef struct {
		logic             act;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] entry;
		logic [VAL_W-1:0] unif;
	} icdf_req_t;

	// one drawn sample as the block reports it
	typedef struct packed {
		logic [LIM_W-1:0] val;
		logic [IDX_W-1:0] bin;
		logic             flat;
		logic             sat;
	} draw_t;

	localparam logic [VAL_W-1:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [VAL_W-1:0] MAX_Q32 = 33'h1_FFFF_FFFF;

	// bins loaded and kept in use, so no search reaches an unloaded entry
	localparam int FILL_BINS = 512;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    req_valid;
	logic                    req_stall;
	logic                    action;
	logic [IDX_W-1:0]        entry_index;
	logic [VAL_W-1:0]        entry_value;
	logic [VAL_W-1:0]        uniform_value;
	logic                    rsp_valid;
	logic                    rsp_stall;
	logic signed [LIM_W-1:0] sample_value;
	logic [IDX_W-1:0]        bin_found;
	logic                    flat_bin;
	logic                    saturated;

	// shadow of the table, updated as requests are accepted, and of the registers, updated as they are written
	logic [VAL_W-1:0]        cdf_shadow [TABLE_DEPTH_DEF];
	logic signed [LIM_W-1:0] lower_reg;
	logic signed [LIM_W-1:0] upper_reg;
	logic [BC_W-1:0]         bins_reg;

	// table as the stimulus generator believes it, for picking hits
	logic [VAL_W-1:0] gen_tbl [TABLE_DEPTH_DEF];

	icdf_req_t pending_reqs [$];
	draw_t     expected_draws [$];
	int        err_cnt;
	bit        req_taken;
	bit        no_idle;
	int        req_gap;
	int        rsp_gap;
	int        hold_asks;
	int        hold_seen;
	int        hold_left;

	inverse_cdf_sampler_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall),
		.action(action), .entry_index(entry_index),
		.entry_value(entry_value), .uniform_value(uniform_value),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.sample_value(sample_value), .bin_found(bin_found),
		.flat_bin(flat_bin), .saturated(saturated)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// piecewise-linear inverse cdf of one uniform
	function automatic draw_t icdf_draw(logic [VAL_W-1:0] u);
		longint n, first, last, mid, b;
		longint diff, edge_off, x, a, ad, dd, d, term;
		logic [VAL_W-1:0] tb_b, prev;
		logic [127:0] num, den, q;
		bit neg;
		draw_t r;
		r = '0;
		if (u == 0)
			return r;
		if (u >= ONE_Q32) begin
			r.val = ONE_Q16;
			return r;
		end
		n = longint'(bins_reg);
		if (n < 1)
			n = 1;
		if (n > TABLE_DEPTH_DEF)
			n = TABLE_DEPTH_DEF;
		first = 0;
		last = n - 1;
		while (first < last) begin
			mid = (first + last) / 2;
			if (u < cdf_shadow[mid])
				last = mid;
			else if (u > cdf_shadow[mid])
				first = mid + 1;
			else begin
				first = mid;
				last = mid;
			end
		end
		b = first;
		tb_b = cdf_shadow[b];
		prev = (b == 0) ? '0 : cdf_shadow[b-1];
		diff = longint'(upper_reg) - longint'(lower_reg);
		edge_off = (diff * (b + 1)) / n;
		x = longint'(lower_reg) + edge_off;
		if (tb_b == prev) begin
			r.flat = 1'b1;
		end else begin
			a = longint'(u) - longint'(tb_b);
			d = (tb_b > prev) ? longint'(tb_b - prev) : longint'(prev - tb_b);
			neg = ((a < 0) != (diff < 0)) != (tb_b < prev);
			ad = (a < 0) ? -a : a;
			dd = (diff < 0) ? -diff : diff;
			num = 128'(ad) * 128'(dd);
			den = 128'(n) * 128'(d);
			q = num / den;
			if (q > (128'd1 << 41))
				q = 128'd1 << 41;
			term = longint'(q[63:0]);
			x = neg ? x - term : x + term;
		end
		if (x > 64'sd2147483647) begin
			x = 64'sd2147483647;
			r.sat = 1'b1;
		end else if (x < -64'sd2147483648) begin
			x = -64'sd2147483648;
			r.sat = 1'b1;
		end
		r.val = x[31:0];
		r.bin = b[IDX_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (no_idle || k < 60)
			return 0;
		if (k < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// request acceptance and prediction
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			req_taken = 1'b1;
			if (action == ACT_LOAD)
				cdf_shadow[entry_index] = entry_value;
			else
				expected_draws.push_back(icdf_draw(uniform_value));
		end
	end

	// request driver
	always @(negedge clk) begin
		icdf_req_t r;
		logic nxt_valid;
		if (arst_n && (!req_valid || req_taken)) begin
			nxt_valid = 1'b0;
			if (req_taken)
				req_gap = pick_gap();
			req_taken = 1'b0;
			if (req_gap > 0) begin
				req_gap--;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				nxt_valid = 1'b1;
				action <= r.act;
				entry_index <= r.idx;
				entry_value <= r.entry;
				uniform_value <= r.unif;
			end
			req_valid <= nxt_valid;
		end
	end

	// response stall, with a long hold-off when the stimulus asks for one
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_gap = pick_gap();
				rsp_stall <= (rsp_gap > 0);
			end
		end
	end

	// response check
	always @(posedge clk) begin
		draw_t got, want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = {sample_value, bin_found, flat_bin, saturated};
			if (expected_draws.size() == 0) begin
				$display("%0t: unexpected response %h", $time, got);
				err_cnt++;
			end else begin
				want = expected_draws.pop_front();
				if (got.val !== want.val) begin
					$display("%0t: sample_value exp %h got %h", $time, want.val, got.val);
					err_cnt++;
				end
				if (got.bin !== want.bin) begin
					$display("%0t: bin_found exp %0d got %0d", $time, want.bin, got.bin);
					err_cnt++;
				end
				if (got.flat !== want.flat) begin
					$display("%0t: flat_bin exp %b got %b", $time, want.flat, got.flat);
					err_cnt++;
				end
				if (got.sat !== want.sat) begin
					$display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
					err_cnt++;
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_valid || expected_draws.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_LOWER)
			lower_reg = data;
		else if (idx == CFG_UPPER)
			upper_reg = data;
		else if (idx == CFG_BINS)
			bins_reg = data[BC_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_load(int idx, logic [VAL_W-1:0] v);
		icdf_req_t r;
		r.act = ACT_LOAD;
		r.idx = IDX_W'(idx);
		r.entry = v;
		r.unif = VAL_W'({$urandom, $urandom});
		gen_tbl[idx] = v;
		pending_reqs.push_back(r);
	endtask

	task automatic push_sample(logic [VAL_W-1:0] u);
		icdf_req_t r;
		r.act = ACT_SAMPLE;
		r.idx = IDX_W'($urandom);
		r.entry = VAL_W'({$urandom, $urandom});
		r.unif = u;
		pending_reqs.push_back(r);
	endtask

	// random mix: mostly draws, some table rewrites
	task automatic random_reqs(int cnt);
		int k, j;
		logic [VAL_W-1:0] v;
		for (int i = 0; i < cnt; i++) begin
			k = $urandom_range(0, 99);
			j = $urandom_range(0, FILL_BINS - 1);
			if (k < 25) begin
				case ($urandom_range(0, 4))
					0: v = (j == 0) ? '0 : gen_tbl[j-1];
					1: v = VAL_W'({$urandom, $urandom});
					2: v = $urandom_range(0, 1) ? MAX_Q32 : '0;
					default: v = (j == 0) ? gen_tbl[0] :
						gen_tbl[j-1] + $urandom_range(0, 8000000);
				endcase
				push_load(j, v);
			end else begin
				k = $urandom_range(0, 99);
				if (k < 3)
					v = '0;
				else if (k < 6)
					v = ONE_Q32;
				else if (k < 9)
					v = ONE_Q32 + $urandom;
				else if (k < 20)
					v = gen_tbl[j];
				else
					v = {1'b0, $urandom};
				push_sample(v);
			end
		end
	endtask

	// stimulus
	initial begin
		logic [VAL_W-1:0] acc;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		action = ACT_LOAD;
		entry_index = '0;
		entry_value = '0;
		uniform_value = '0;
		rsp_stall = 1'b0;
		err_cnt = 0;
		req_taken = 1'b0;
		no_idle = 1'b0;
		req_gap = 0;
		rsp_gap = 0;
		hold_asks = 0;
		hold_seen = 0;
		hold_left = 0;
		lower_reg = LOWER_RST;
		upper_reg = UPPER_RST;
		bins_reg = BINS_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// only the loaded bins are searched
		write_reg(CFG_BINS, 32'(FILL_BINS));

		// fill the bins in use with a rising cdf, some bins flat
		acc = '0;
		for (int i = 0; i < FILL_BINS; i++) begin
			if ($urandom_range(0, 9) != 0)
				acc = acc + $urandom_range(1, 8000000);
			if (acc > ONE_Q32 || i == FILL_BINS - 1)
				acc = ONE_Q32;
			push_load(i, acc);
		end

		// directed draws: zero, one, above one, table hits, the ends
		push_sample('0);
		push_sample(ONE_Q32);
		push_sample(MAX_Q32);
		push_sample(33'd1);
		push_sample(ONE_Q32 - 1);
		push_sample(gen_tbl[0]);
		push_sample(gen_tbl[FILL_BINS/2 - 1]);
		push_sample(gen_tbl[FILL_BINS - 2]);
		for (int i = 0; i < 8; i++)
			push_sample({1'b0, $urandom});
		wait_idle();

		// default limits, random traffic, receiver holds off for a while
		hold_asks++;
		random_reqs(100);
		wait_idle();

		// widest range, no idling
		write_reg(CFG_LOWER, 32'h8000_0000);
		write_reg(CFG_UPPER, 32'h7FFF_FFFF);
		no_idle = 1'b1;
		random_reqs(100);
		wait_idle();
		no_idle = 1'b0;

		// reversed range and a single bin
		write_reg(CFG_LOWER, 32'h7FFF_FFFF);
		write_reg(CFG_UPPER, 32'h8000_0000);
		write_reg(CFG_BINS, 32'd1);
		random_reqs(60);
		wait_idle();

		// bin count zero, then a write with junk above the count bits
		write_reg(CFG_BINS, 32'd0);
		random_reqs(30);
		wait_idle();
		write_reg(CFG_BINS, {21'($urandom_range(0, 2097151)), 11'(FILL_BINS)});
		write_reg(CFG_LOWER, $urandom);
		random_reqs(40);
		wait_idle();

		// assorted settings
		for (int p = 0; p < 4; p++) begin
			write_reg(CFG_LOWER, $urandom_range(0, 1) ? $urandom : -$urandom_range(0, 300000));
			write_reg(CFG_UPPER, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 300000));
			write_reg(CFG_BINS, $urandom_range(1, FILL_BINS));
			random_reqs(25);
			wait_idle();
		end

		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

endmodule
